### design/page_replacement_fifo_lru_unit_macros.svh
// ----------------------------------------------------------------------------
// Page replacement unit assertion macros
// Shared concurrent assertion forms for the page replacement unit.
// ----------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_FIFO_LRU_UNIT_MACROS_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PRFL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prfl: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PRFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prfl: next-cycle check failed");

`endif

### design/prfl_pkg.sv
// ----------------------------------------------------------------------------
// Page replacement unit package
// Fixed widths, saturation limits, policy codes and the split control struct.
// ----------------------------------------------------------------------------
package prfl_pkg;

   // Fixed field widths
   localparam int AGE_BITS   = 16;
   localparam int FAULT_BITS = 32;

   localparam logic [AGE_BITS-1:0]   AGE_MAX   = {AGE_BITS{1'b1}};
   localparam logic [FAULT_BITS-1:0] FAULT_MAX = {FAULT_BITS{1'b1}};

   // Victim policy
   typedef enum logic {
      MODE_FIFO = 1'b0,
      MODE_LRU  = 1'b1
   } mode_type;

   // Sequencer controls for the address split unit
   typedef struct packed {
      logic load;   // capture a new access address
      logic mul;    // register the reciprocal product
   } split_ctrl_type;

endpackage

### design/prfl_split.sv
// ----------------------------------------------------------------------------
// Address split unit
// Divides the access address by the page size through a registered
// reciprocal multiply and one correction step, giving page and offset.
// ----------------------------------------------------------------------------
module prfl_split
   import prfl_pkg::*;
#(
   parameter int ADDR_BITS  = 12,
   parameter int PAGE_WORDS = 16,
   parameter int PAGE_BITS  = 8,
   parameter int OFF_BITS   = 4
) (
   input  logic                 clock,
   input  split_ctrl_type       ctrl,
   input  logic [ADDR_BITS-1:0] access_address,
   output logic [PAGE_BITS-1:0] page_number,
   output logic [OFF_BITS-1:0]  page_offset
);

   // floor(2^ADDR_BITS / PAGE_WORDS) leaves the quotient at most one short
   localparam logic [63:0] RECIP_WIDE = (64'd1 << ADDR_BITS) / PAGE_WORDS;
   localparam int          PROD_BITS  = 2 * ADDR_BITS;
   localparam int          REM_BITS   = ADDR_BITS + 9;

   logic [ADDR_BITS-1:0] addr_ff;
   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] prod_in;
   logic [ADDR_BITS-1:0] quot_est;
   logic [ADDR_BITS-1:0] quot;
   logic [REM_BITS-1:0]  rem_est;
   logic [REM_BITS-1:0]  rem;

   // Reciprocal product
   assign prod_in = PROD_BITS'(addr_ff) * PROD_BITS'(RECIP_WIDE[ADDR_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         addr_ff <= access_address;
      end
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
   end

   // Remainder check and single correction
   always_comb begin
      quot_est = prod_ff[PROD_BITS-1:ADDR_BITS];
      rem_est  = REM_BITS'(addr_ff) - REM_BITS'(quot_est) * REM_BITS'(PAGE_WORDS);
      if (rem_est >= REM_BITS'(PAGE_WORDS)) begin
         quot = quot_est + 1'b1;
         rem  = rem_est - REM_BITS'(PAGE_WORDS);
      end else begin
         quot = quot_est;
         rem  = rem_est;
      end
   end

   assign page_number = quot[PAGE_BITS-1:0];
   assign page_offset = rem[OFF_BITS-1:0];

endmodule

### design/page_replacement_fifo_lru_unit.sv
// ----------------------------------------------------------------------------
// Page replacement unit, FIFO or LRU victim choice
// Looks up each access page among the resident frames, fills or evicts on a
// fault and reports the frame, any evicted page and a running fault count.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   req_access_address             start high while busy low
//  response  rsp_hit .. rsp_fault_total     rsp_valid, one cycle, no stall
//  csr       csr_write_data                 csr_write_enable, single register
//
// An item runs from start through a multiply state for the page split, scan
// states through the single tag/age compare unit, one frame each (up to the
// hit frame, or over the frames filled on a fault), an update state, then
// the rsp_valid cycle, in which start is taken again.
// Synchronous reset clears frames, ages, pointer and count; mode resets LRU.
// The receiver cannot stall; results are strobed once.
// ----------------------------------------------------------------------------
`include "page_replacement_fifo_lru_unit_macros.svh"

module page_replacement_fifo_lru_unit
   import prfl_pkg::*;
#(
   parameter int FRAMES     = 4,
   parameter int PAGE_WORDS = 16,
   parameter int ADDR_BITS  = 12,
   localparam longint unsigned PAGE_MAX = ((64'd1 << ADDR_BITS) - 64'd1) / PAGE_WORDS,
   localparam int PAGE_BITS  = (PAGE_MAX == 0) ? 1 : $clog2(PAGE_MAX + 1),
   localparam int OFF_BITS   = $clog2(PAGE_WORDS),
   localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ADDR_BITS-1:0]  req_access_address,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [FRAME_BITS-1:0] rsp_frame_used,
   output logic [PAGE_BITS-1:0]  rsp_page_number,
   output logic [OFF_BITS-1:0]   rsp_page_offset,
   output logic                  rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]  rsp_evicted_page,
   output logic [FAULT_BITS-1:0] rsp_fault_total,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data
);

   localparam int FILL_BITS = $clog2(FRAMES + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_SCAN,
      S_UPDATE
   } state_type;

   // Sequencer and frame state
   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [PAGE_BITS-1:0]  tag_ff [FRAMES];
   logic [PAGE_BITS-1:0]  tag_in [FRAMES];
   logic [AGE_BITS-1:0]   age_ff [FRAMES];
   logic [AGE_BITS-1:0]   age_in [FRAMES];
   logic [FILL_BITS-1:0]  filled_ff, filled_in;
   logic [FRAME_BITS-1:0] fifo_ptr_ff, fifo_ptr_in;
   logic [FAULT_BITS-1:0] fault_ff, fault_in;

   // Scan registers
   logic [FRAME_BITS-1:0] idx_ff, idx_in;
   logic                  hit_ff, hit_in;
   logic [FRAME_BITS-1:0] old_idx_ff, old_idx_in;
   logic [AGE_BITS-1:0]   old_age_ff, old_age_in;
   logic [PAGE_BITS-1:0]  old_tag_ff, old_tag_in;
   logic [PAGE_BITS-1:0]  fifo_tag_ff, fifo_tag_in;

   // Registered result
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [FRAME_BITS-1:0] rsp_frame_ff, rsp_frame_in;
   logic [PAGE_BITS-1:0]  rsp_page_ff, rsp_page_in;
   logic [OFF_BITS-1:0]   rsp_offset_ff, rsp_offset_in;
   logic                  rsp_evicted_valid_ff, rsp_evicted_valid_in;
   logic [PAGE_BITS-1:0]  rsp_evicted_page_ff, rsp_evicted_page_in;

   split_ctrl_type        split_ctrl;
   logic [PAGE_BITS-1:0]  page;
   logic [OFF_BITS-1:0]   offset;
   logic                  accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign split_ctrl = '{load: accept, mul: (state_ff == S_MUL)};

   prfl_split #(
      .ADDR_BITS  (ADDR_BITS),
      .PAGE_WORDS (PAGE_WORDS),
      .PAGE_BITS  (PAGE_BITS),
      .OFF_BITS   (OFF_BITS)
   ) u_split (
      .clock          (clock),
      .ctrl           (split_ctrl),
      .access_address (req_access_address),
      .page_number    (page),
      .page_offset    (offset)
   );

   // Next-state logic: scan one frame per cycle, then update all at once
   always_comb begin
      logic [PAGE_BITS-1:0]  scan_tag;
      logic [AGE_BITS-1:0]   scan_age;
      logic                  last;
      logic                  full;
      logic                  miss;
      logic [FRAME_BITS-1:0] frame;
      logic [AGE_BITS-1:0]   age_base;

      state_in             = state_ff;
      mode_in              = mode_ff;
      tag_in               = tag_ff;
      age_in               = age_ff;
      filled_in            = filled_ff;
      fifo_ptr_in          = fifo_ptr_ff;
      fault_in             = fault_ff;
      idx_in               = idx_ff;
      hit_in               = hit_ff;
      old_idx_in           = old_idx_ff;
      old_age_in           = old_age_ff;
      old_tag_in           = old_tag_ff;
      fifo_tag_in          = fifo_tag_ff;
      rsp_valid_in         = 1'b0;
      rsp_hit_in           = rsp_hit_ff;
      rsp_frame_in         = rsp_frame_ff;
      rsp_page_in          = rsp_page_ff;
      rsp_offset_in        = rsp_offset_ff;
      rsp_evicted_valid_in = rsp_evicted_valid_ff;
      rsp_evicted_page_in  = rsp_evicted_page_ff;

      scan_tag = tag_ff[idx_ff];
      scan_age = age_ff[idx_ff];
      last     = ((FILL_BITS+1)'(idx_ff) + 1'b1) == (FILL_BITS+1)'(filled_ff);
      full     = (filled_ff == FILL_BITS'(FRAMES));
      miss     = !hit_ff;
      frame    = idx_ff;
      age_base = '0;

      if (csr_write_enable) begin
         mode_in = mode_type'(csr_write_data);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = (filled_ff == '0) ? S_UPDATE : S_SCAN;
         end
         S_SCAN: begin
            if (scan_tag == page) begin
               hit_in   = 1'b1;
               state_in = S_UPDATE;
            end else begin
               // oldest so far; strict compare keeps the lowest index on a tie
               if (idx_ff == '0 || scan_age > old_age_ff) begin
                  old_idx_in = idx_ff;
                  old_age_in = scan_age;
                  old_tag_in = scan_tag;
               end
               if (idx_ff == fifo_ptr_ff) begin
                  fifo_tag_in = scan_tag;
               end
               if (last) begin
                  state_in = S_UPDATE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_UPDATE: begin
            rsp_evicted_valid_in = 1'b0;
            rsp_evicted_page_in  = '0;
            if (miss) begin
               if (fault_ff != FAULT_MAX) begin
                  fault_in = fault_ff + 1'b1;
               end
               if (!full) begin
                  frame     = FRAME_BITS'(filled_ff);
                  filled_in = filled_ff + 1'b1;
               end else begin
                  rsp_evicted_valid_in = 1'b1;
                  if (mode_ff == MODE_FIFO) begin
                     frame               = fifo_ptr_ff;
                     rsp_evicted_page_in = fifo_tag_ff;
                     fifo_ptr_in = (fifo_ptr_ff == FRAME_BITS'(FRAMES - 1)) ?
                                   '0 : fifo_ptr_ff + 1'b1;
                  end else begin
                     frame               = old_idx_ff;
                     rsp_evicted_page_in = old_tag_ff;
                  end
               end
               tag_in[frame] = page;
            end
            // touched frame restarts, filled frames age by one, saturating
            for (int i = 0; i < FRAMES; i++) begin
               age_base = (FRAME_BITS'(i) == frame) ? '0 : age_ff[i];
               if (FILL_BITS'(i) < filled_in && age_base != AGE_MAX) begin
                  age_in[i] = age_base + 1'b1;
               end else begin
                  age_in[i] = age_base;
               end
            end
            rsp_valid_in  = 1'b1;
            rsp_hit_in    = hit_ff;
            rsp_frame_in  = frame;
            rsp_page_in   = page;
            rsp_offset_in = offset;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_LRU;
         filled_ff    <= '0;
         fifo_ptr_ff  <= '0;
         fault_ff     <= '0;
         hit_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FRAMES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         filled_ff    <= filled_in;
         fifo_ptr_ff  <= fifo_ptr_in;
         fault_ff     <= fault_in;
         hit_ff       <= hit_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         age_ff       <= age_in;
      end
      tag_ff               <= tag_in;
      old_idx_ff           <= old_idx_in;
      old_age_ff           <= old_age_in;
      old_tag_ff           <= old_tag_in;
      fifo_tag_ff          <= fifo_tag_in;
      rsp_hit_ff           <= rsp_hit_in;
      rsp_frame_ff         <= rsp_frame_in;
      rsp_page_ff          <= rsp_page_in;
      rsp_offset_ff        <= rsp_offset_in;
      rsp_evicted_valid_ff <= rsp_evicted_valid_in;
      rsp_evicted_page_ff  <= rsp_evicted_page_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_used    = rsp_frame_ff;
   assign rsp_page_number   = rsp_page_ff;
   assign rsp_page_offset   = rsp_offset_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_total   = fault_ff;

   // Checks
   `PRFL_ASSERT_IMPLY(a_rsp_from_update, clock, reset, rsp_valid_ff, $past(state_ff == S_UPDATE))
   `PRFL_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, filled_ff <= FILL_BITS'(FRAMES))
   `PRFL_ASSERT_IMPLY(a_evict_on_full_miss, clock, reset, rsp_valid_ff && rsp_evicted_valid_ff, !rsp_hit_ff && filled_ff == FILL_BITS'(FRAMES))
   `PRFL_ASSERT_NEXT(a_busy_after_start, clock, reset, accept, busy)

endmodule

### dv/page_replacement_fifo_lru_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement unit checker
// Watches the request, response and csr ports of the page replacement unit.
// Keeps its own copy of the frame tags, ages, fill count, FIFO pointer, fault
// count and policy, works out the outcome of every accepted access and
// compares each strobed response against the oldest outstanding outcome.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_unit_checker
   import prfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [11:0]           req_access_address,
   input  logic                  rsp_valid,
   input  logic                  rsp_hit,
   input  logic [1:0]            rsp_frame_used,
   input  logic [7:0]            rsp_page_number,
   input  logic [3:0]            rsp_page_offset,
   input  logic                  rsp_evicted_valid,
   input  logic [7:0]            rsp_evicted_page,
   input  logic [FAULT_BITS-1:0] rsp_fault_total,
   input  logic                  csr_write_enable,
   input  logic                  csr_write_data,
   output int                    mismatch_count,
   output int                    pending_results
);

   localparam int FRAMES     = 4;
   localparam int ADDR_BITS  = 12;
   localparam int OFF_BITS   = 4;
   localparam int PAGE_BITS  = 8;
   localparam int FRAME_BITS = 2;

   typedef struct packed {
      logic                  hit;
      logic [FRAME_BITS-1:0] frame;
      logic [PAGE_BITS-1:0]  page;
      logic [OFF_BITS-1:0]   offset;
      logic                  evicted_valid;
      logic [PAGE_BITS-1:0]  evicted_page;
      logic [FAULT_BITS-1:0] faults;
   } access_outcome_type;

   // Mirrored replacement state
   logic [PAGE_BITS-1:0]  tag_of [FRAMES];
   logic [AGE_BITS-1:0]   age_of [FRAMES];
   int unsigned           frames_used;
   logic [FRAME_BITS-1:0] fifo_ptr;
   logic [FAULT_BITS-1:0] fault_cnt;
   mode_type              policy;

   access_outcome_type    pending_outcomes[$];

   // Lookup, fill or evict, then age every filled frame
   function automatic access_outcome_type resolve_access(input logic [ADDR_BITS-1:0] addr);
      access_outcome_type o;
      int unsigned        f;
      o        = '0;
      f        = 0;
      o.page   = addr[ADDR_BITS-1:OFF_BITS];
      o.offset = addr[OFF_BITS-1:0];
      for (int i = 0; i < frames_used; i++) begin
         if (!o.hit && tag_of[i] == o.page) begin
            o.hit = 1'b1;
            f     = i;
         end
      end
      if (!o.hit) begin
         if (fault_cnt != FAULT_MAX) fault_cnt = fault_cnt + 1'b1;
         if (frames_used < FRAMES) begin
            f           = frames_used;
            frames_used = frames_used + 1;
         end else begin
            if (policy == MODE_FIFO) begin
               f        = 32'(fifo_ptr);
               fifo_ptr = fifo_ptr + 1'b1;
            end else begin
               // oldest frame, lowest index wins a tie
               f = 0;
               for (int i = 1; i < FRAMES; i++)
                  if (age_of[i] > age_of[f]) f = i;
            end
            o.evicted_valid = 1'b1;
            o.evicted_page  = tag_of[f];
         end
         tag_of[f] = o.page;
      end
      age_of[f] = '0;
      for (int i = 0; i < frames_used; i++)
         if (age_of[i] != AGE_MAX) age_of[i] = age_of[i] + 1'b1;
      o.frame  = f[FRAME_BITS-1:0];
      o.faults = fault_cnt;
      return o;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
      mismatch_count = mismatch_count + 1;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) flag_mismatch(what, got, want);
   endtask

   // Sample all channels at the rising edge
   always @(posedge clock) begin : watch
      access_outcome_type want;
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            tag_of[i] = '0;
            age_of[i] = '0;
         end
         frames_used    = 0;
         fifo_ptr       = '0;
         fault_cnt      = '0;
         policy         = MODE_LRU;
         mismatch_count = 0;
         pending_outcomes.delete();
      end else begin
         if (csr_write_enable) policy = mode_type'(csr_write_data);
         if (rsp_valid) begin
            if (pending_outcomes.size() == 0) begin
               flag_mismatch("unexpected response", 32'd1, 32'd0);
            end else begin
               want = pending_outcomes.pop_front();
               check_field("hit", 32'(rsp_hit), 32'(want.hit));
               check_field("frame_used", 32'(rsp_frame_used), 32'(want.frame));
               check_field("page_number", 32'(rsp_page_number), 32'(want.page));
               check_field("page_offset", 32'(rsp_page_offset), 32'(want.offset));
               check_field("evicted_valid", 32'(rsp_evicted_valid),
                           32'(want.evicted_valid));
               check_field("evicted_page", 32'(rsp_evicted_page),
                           32'(want.evicted_page));
               check_field("fault_total", rsp_fault_total, want.faults);
            end
         end
         if (start && !busy) pending_outcomes.push_back(resolve_access(req_access_address));
      end
      pending_results <= pending_outcomes.size();
   end

endmodule

### dv/page_replacement_fifo_lru_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page replacement unit testbench
// Drives access items into the page replacement unit with random idle gaps,
// switches the victim policy between phases, and leaves prediction and
// comparison to the checker. Covers an LRU victim choice after a long run of
// hits, FIFO pointer rotation across policy changes, and random hot-set
// traffic.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_unit_tb;
   import prfl_pkg::*;

   localparam int IDLE_PCT     = 13;
   localparam int PHASE_ITEMS  = 190;
   localparam int PHASES       = 8;
   localparam int HOT_RUN      = 64;
   // longest quiet stretch is a settle pause or a run of idle cycles
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 10;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [11:0]           req_access_address;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic [1:0]            rsp_frame_used;
   logic [7:0]            rsp_page_number;
   logic [3:0]            rsp_page_offset;
   logic                  rsp_evicted_valid;
   logic [7:0]            rsp_evicted_page;
   logic [FAULT_BITS-1:0] rsp_fault_total;
   logic                  csr_write_enable;
   logic                  csr_write_data;

   int                    mismatch_count;
   int                    pending_results;
   int                    quiet_cycles;
   logic                  idle_on;
   logic [7:0]            hot_pages [8];
   int                    hot_count;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   page_replacement_fifo_lru_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_access_address (req_access_address),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_frame_used     (rsp_frame_used),
      .rsp_page_number    (rsp_page_number),
      .rsp_page_offset    (rsp_page_offset),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_total    (rsp_fault_total),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   page_replacement_fifo_lru_unit_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_access_address (req_access_address),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_frame_used     (rsp_frame_used),
      .rsp_page_number    (rsp_page_number),
      .rsp_page_offset    (rsp_page_offset),
      .rsp_evicted_valid  (rsp_evicted_valid),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_fault_total    (rsp_fault_total),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .pending_results    (pending_results)
   );

   // Enter and leave at a falling edge; optional idle cycles first
   task automatic send_access(input logic [11:0] addr);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start              <= 1'b1;
      req_access_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Wait until every response is back and the unit is quiet
   task automatic settle();
      start <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly hot-set pages with random offsets, the rest anywhere
   function automatic logic [11:0] pick_address();
      logic [7:0] pg;
      logic [3:0] off;
      off = 4'($urandom_range(15));
      if ($urandom_range(99) < 65) begin
         pg = hot_pages[$urandom_range(hot_count - 1)];
         return {pg, off};
      end
      return 12'($urandom_range(4095));
   endfunction

   // Watchdog on cycles with no item moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("page_replacement_fifo_lru_unit_tb: errors");
         $finish;
      end
   end

   initial begin
      mode_type   m;
      logic [3:0] off;
      start              = 1'b0;
      req_access_address = '0;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      reset              = 1'b1;
      idle_on            = 1'b0;
      hot_count          = 1;
      for (int h = 0; h < 8; h++) hot_pages[h] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // LRU victim: frames 0 and 1 grow old while 2 and 3 are hit
      send_access(12'h100);
      send_access(12'h11F);
      send_access(12'h120);
      send_access(12'h13A);
      send_access(12'h105);
      for (int n = 0; n < HOT_RUN; n++) begin
         off = 4'($urandom_range(15));
         send_access({7'h09, n[0], off});
      end
      send_access(12'h200);
      send_access(12'h210);

      // Directed: address extremes, hits, FIFO rotation, policy switches
      idle_on = 1'b1;
      send_access(12'h000);
      send_access(12'hFFF);
      send_access(12'h5A5);
      send_access(12'hA5A);
      send_access(12'hFF0);
      write_mode(MODE_FIFO);
      send_access(12'h300);
      send_access(12'h310);
      send_access(12'h320);
      send_access(12'h30F);
      write_mode(MODE_LRU);
      send_access(12'h400);
      send_access(12'h410);
      send_access(12'h40C);
      write_mode(MODE_FIFO);
      send_access(12'h420);
      send_access(12'h430);
      send_access(12'hFFF);
      send_access(12'h000);

      // Random phases over a per-phase hot set
      for (int p = 0; p < PHASES; p++) begin
         if (p >= 6) m = mode_type'($urandom_range(1));
         else m = (p % 2 == 0) ? MODE_LRU : MODE_FIFO;
         write_mode(m);
         hot_count = $urandom_range(7, 3);
         for (int h = 0; h < hot_count; h++) hot_pages[h] = 8'($urandom_range(255));
         idle_on = (p != 3);
         repeat (PHASE_ITEMS) send_access(pick_address());
      end

      start <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (2 * SETTLE_TICKS) @(negedge clock);
      if (mismatch_count == 0)
         $display("page_replacement_fifo_lru_unit_tb: clean");
      else
         $display("page_replacement_fifo_lru_unit_tb: errors");
      $finish;
   end

endmodule
